FILE: rtl/crw_pkg.sv
// shared types, constants and helper functions of the constraint row allocator
package crw_pkg;

    localparam int CONSTRAINTS = 32;
    localparam int IDX_W       = $clog2(CONSTRAINTS);
    localparam int COUNT_W     = $clog2(CONSTRAINTS + 1);
    localparam int GRP_SIZE    = 8;
    localparam int GRP_BIT_W   = $clog2(GRP_SIZE);
    localparam int GROUPS      = CONSTRAINTS / GRP_SIZE;
    localparam int GRP_W       = $clog2(GROUPS);

    localparam logic [2:0] BND_NONE  = 3'd0;
    localparam logic [2:0] BND_LOWER = 3'd1;
    localparam logic [2:0] BND_TWIN  = 3'd4;

    typedef enum logic [2:0] {
        ACT_AT_ROW     = 3'd0,
        ACT_FIRST_FREE = 3'd1,
        ACT_RELEASE    = 3'd2,
        ACT_FREEZE     = 3'd3,
        ACT_QUERY_CON  = 3'd4,
        ACT_QUERY_ROW  = 3'd5,
        ACT_LIST       = 3'd6,
        ACT_CLEAR      = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_ALREADY_ACTIVE = 3'd1,
        ST_ROW_BUSY       = 3'd2,
        ST_BOUND_NONE     = 3'd3,
        ST_NO_FREE_ROW    = 3'd4,
        ST_NOT_ACTIVE     = 3'd5,
        ST_ALREADY_FROZEN = 3'd6,
        ST_LIST_EMPTY     = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_EXEC,
        S_EMIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ACTIVATE,
        WR_RELEASE,
        WR_FREEZE,
        WR_CLEAR
    } t_write_op;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] constraint_ref;
        logic [2:0] bound_type;
        logic [4:0] row_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] constraint_out;
        logic [4:0] row_out;
        logic [2:0] bound_out;
        logic       frozen_out;
        logic       negative_sign;
        logic       row_free_out;
        logic [5:0] active_count;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic row_step;
        logic exec_step;
        logic emit_step;
        logic list_next;
    } t_ctrl_cmd;

    typedef struct packed {
        logic list_more;
    } t_dp_stat;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick;

    // lowest set bit, found in two levels: first group, then bit in group
    function automatic t_pick first_set(input logic [CONSTRAINTS-1:0] v);
        logic [GROUPS-1:0]   any;
        logic [GRP_W-1:0]    g;
        logic [GRP_SIZE-1:0] sel;
        t_pick               p;
        for (int gi = 0; gi < GROUPS; gi++) begin
            any[gi] = |v[gi*GRP_SIZE +: GRP_SIZE];
        end
        g = '0;
        for (int gi = GROUPS - 1; gi >= 0; gi--) begin
            if (any[gi]) begin
                g = GRP_W'(gi);
            end
        end
        sel   = v[{g, GRP_BIT_W'(0)} +: GRP_SIZE];
        p.idx = '0;
        for (int bi = GRP_SIZE - 1; bi >= 0; bi--) begin
            if (sel[bi]) begin
                p.idx = {g, GRP_BIT_W'(bi)};
            end
        end
        p.found = |any;
        return p;
    endfunction

endpackage

FILE: rtl/crw_if.sv
// request and response channel interfaces of the constraint row allocator
interface crw_req_if;
    logic               valid;
    logic               ready;
    crw_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crw_rsp_if;
    logic               valid;
    logic               ready;
    crw_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/crw_controller.sv
// sequencing state machine of the constraint row allocator
module crw_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  crw_pkg::t_dp_stat   i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output crw_pkg::t_ctrl_cmd  o_cmd
);

    crw_pkg::t_state r_state;
    crw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            crw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = crw_pkg::S_ROW;
                end
            end
            crw_pkg::S_ROW:  n_state = crw_pkg::S_EXEC;
            crw_pkg::S_EXEC: n_state = crw_pkg::S_EMIT;
            crw_pkg::S_EMIT: n_state = crw_pkg::S_OUT;
            crw_pkg::S_OUT: begin
                if (i_out_ready) begin
                    // list walks on to the next busy row
                    n_state = i_stat.list_more ? crw_pkg::S_ROW : crw_pkg::S_IDLE;
                end
            end
            default: n_state = crw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd           = '0;
        case (r_state)
            crw_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            crw_pkg::S_ROW:  o_cmd.row_step  = 1'b1;
            crw_pkg::S_EXEC: o_cmd.exec_step = 1'b1;
            crw_pkg::S_EMIT: o_cmd.emit_step = 1'b1;
            crw_pkg::S_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.list_next = i_out_ready && i_stat.list_more;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/crw_datapath.sv
// allocation tables, row lookup, update logic and result register
module crw_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crw_pkg::t_ctrl_cmd  i_cmd,
    input  crw_pkg::t_in_item   i_in_item,
    output crw_pkg::t_out_item  o_out_item,
    output crw_pkg::t_dp_stat   o_stat
);

    localparam int N  = crw_pkg::CONSTRAINTS;
    localparam int IW = crw_pkg::IDX_W;
    localparam int CW = crw_pkg::COUNT_W;

    // allocation tables
    logic [2:0]    r_bound     [N];
    logic [IW-1:0] r_crow      [N];
    logic [IW-1:0] r_owner_tab [N];
    logic [N-1:0]  r_free;
    logic [N-1:0]  r_frozen;
    logic [CW-1:0] r_count;

    // working registers of the current item
    crw_pkg::t_in_item  r_item;
    logic [IW-1:0]      r_ptr;
    logic [IW-1:0]      r_row;
    logic               r_rfree;
    logic               r_found;
    logic               r_more;
    logic [IW-1:0]      r_c;
    crw_pkg::t_status   r_status;
    logic               r_desc;
    logic [IW-1:0]      r_rowhint;
    logic               r_rf;
    logic               r_last;
    crw_pkg::t_out_item r_out;

    crw_pkg::t_action   act;
    logic [N-1:0]       busy;
    logic [N-1:0]       lmask;
    crw_pkg::t_pick     pick_free;
    crw_pkg::t_pick     pick_busy;
    logic [IW-1:0]      sel_row;
    logic               sel_found;
    logic               owner_based;

    crw_pkg::t_status   ex_status;
    logic               ex_desc;
    logic [IW-1:0]      ex_rowhint;
    logic               ex_rf;
    crw_pkg::t_write_op ex_op;
    logic [2:0]         bnd_c;
    logic               bad_type;

    logic [2:0]         em_bound;
    logic               em_active;

    assign act       = crw_pkg::t_action'(r_item.action);
    assign busy      = ~r_free;
    assign lmask     = busy & ({N{1'b1}} << r_ptr);
    assign pick_free = crw_pkg::first_set(r_free);
    assign pick_busy = crw_pkg::first_set(lmask);

    always_comb begin
        case (act)
            crw_pkg::ACT_FIRST_FREE: begin
                sel_row   = pick_free.idx;
                sel_found = pick_free.found;
            end
            crw_pkg::ACT_LIST: begin
                sel_row   = pick_busy.idx;
                sel_found = pick_busy.found;
            end
            default: begin
                sel_row   = IW'(r_item.row_index);
                sel_found = 1'b1;
            end
        endcase
    end

    assign owner_based = (act == crw_pkg::ACT_RELEASE) || (act == crw_pkg::ACT_QUERY_ROW)
                      || (act == crw_pkg::ACT_LIST);

    // decision of the step, taken on the tables before the update
    assign bnd_c    = r_bound[r_c];
    assign bad_type = (r_item.bound_type == crw_pkg::BND_NONE)
                   || (r_item.bound_type > crw_pkg::BND_TWIN);

    always_comb begin
        ex_status  = crw_pkg::ST_OK;
        ex_desc    = 1'b1;
        ex_rowhint = '0;
        ex_rf      = 1'b0;
        ex_op      = crw_pkg::WR_NONE;
        case (act)
            crw_pkg::ACT_AT_ROW: begin
                if (bnd_c != crw_pkg::BND_NONE) begin
                    ex_status = crw_pkg::ST_ALREADY_ACTIVE;
                end else if (!r_rfree) begin
                    ex_status = crw_pkg::ST_ROW_BUSY;
                end else if (bad_type) begin
                    ex_status = crw_pkg::ST_BOUND_NONE;
                end else begin
                    ex_op = crw_pkg::WR_ACTIVATE;
                end
            end
            crw_pkg::ACT_FIRST_FREE: begin
                if (!r_found) begin
                    ex_status = crw_pkg::ST_NO_FREE_ROW;
                end else if (bnd_c != crw_pkg::BND_NONE) begin
                    ex_status = crw_pkg::ST_ALREADY_ACTIVE;
                end else if (bad_type) begin
                    ex_status = crw_pkg::ST_BOUND_NONE;
                end else begin
                    ex_op = crw_pkg::WR_ACTIVATE;
                end
            end
            crw_pkg::ACT_RELEASE: begin
                ex_rowhint = r_row;
                ex_rf      = 1'b1;
                if (r_rfree) begin
                    ex_status = crw_pkg::ST_NOT_ACTIVE;
                    ex_desc   = 1'b0;
                end else begin
                    ex_op = crw_pkg::WR_RELEASE;
                end
            end
            crw_pkg::ACT_FREEZE: begin
                if (bnd_c == crw_pkg::BND_NONE) begin
                    ex_status = crw_pkg::ST_NOT_ACTIVE;
                end else if (bnd_c == crw_pkg::BND_TWIN || r_frozen[r_c]) begin
                    ex_status = crw_pkg::ST_ALREADY_FROZEN;
                end else begin
                    ex_op = crw_pkg::WR_FREEZE;
                end
            end
            crw_pkg::ACT_QUERY_CON: begin
                if (bnd_c == crw_pkg::BND_NONE) begin
                    ex_status = crw_pkg::ST_NOT_ACTIVE;
                end
            end
            crw_pkg::ACT_QUERY_ROW: begin
                ex_rowhint = r_row;
                if (r_rfree) begin
                    ex_status = crw_pkg::ST_NOT_ACTIVE;
                    ex_desc   = 1'b0;
                    ex_rf     = 1'b1;
                end
            end
            crw_pkg::ACT_LIST: begin
                if (!r_found) begin
                    ex_status = crw_pkg::ST_LIST_EMPTY;
                    ex_desc   = 1'b0;
                end else begin
                    ex_rowhint = r_row;
                end
            end
            crw_pkg::ACT_CLEAR: begin
                ex_desc = 1'b0;
                ex_op   = crw_pkg::WR_CLEAR;
            end
            default: begin
                ex_op = crw_pkg::WR_NONE;
            end
        endcase
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.exec_step && ex_op == crw_pkg::WR_CLEAR)) begin
            r_bound     <= '{default: crw_pkg::BND_NONE};
            r_crow      <= '{default: '0};
            r_owner_tab <= '{default: '0};
            r_free      <= '1;
            r_frozen    <= '0;
            r_count     <= '0;
        end else if (i_cmd.exec_step) begin
            case (ex_op)
                crw_pkg::WR_ACTIVATE: begin
                    r_bound[r_c]       <= r_item.bound_type;
                    r_crow[r_c]        <= r_row;
                    r_owner_tab[r_row] <= r_c;
                    r_free[r_row]      <= 1'b0;
                    r_count            <= r_count + 1'b1;
                end
                crw_pkg::WR_RELEASE: begin
                    r_bound[r_c]       <= crw_pkg::BND_NONE;
                    r_crow[r_c]        <= '0;
                    r_owner_tab[r_row] <= '0;
                    r_free[r_row]      <= 1'b1;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                crw_pkg::WR_FREEZE: begin
                    r_frozen[r_c] <= 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // item, row lookup and step registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_item;
            r_ptr  <= '0;
        end
        if (i_cmd.list_next) begin
            r_ptr <= r_row + 1'b1;
        end
        if (i_cmd.row_step) begin
            r_row   <= sel_row;
            r_found <= sel_found;
            r_rfree <= r_free[sel_row];
            r_c     <= owner_based ? r_owner_tab[sel_row] : IW'(r_item.constraint_ref);
            // another busy row lies above the one picked
            r_more  <= (act == crw_pkg::ACT_LIST) && (|(lmask & (lmask - 1'b1)));
        end
        if (i_cmd.exec_step) begin
            r_status  <= ex_status;
            r_desc    <= ex_desc;
            r_rowhint <= ex_rowhint;
            r_rf      <= ex_rf;
            r_last    <= (act == crw_pkg::ACT_LIST) ? !r_more : 1'b1;
        end
        if (i_cmd.emit_step) begin
            r_out.status         <= r_status;
            r_out.constraint_out <= r_desc ? 5'(r_c) : 5'd0;
            r_out.row_out        <= em_active ? 5'(r_crow[r_c]) : 5'(r_rowhint);
            r_out.bound_out      <= em_active ? em_bound : crw_pkg::BND_NONE;
            r_out.frozen_out     <= em_active
                                 && (em_bound == crw_pkg::BND_TWIN || r_frozen[r_c]);
            r_out.negative_sign  <= em_active && (em_bound == crw_pkg::BND_LOWER);
            r_out.row_free_out   <= r_rf;
            r_out.active_count   <= 6'(r_count);
            r_out.last           <= r_last;
        end
    end

    // result describes the tables after the update
    assign em_bound  = r_bound[r_c];
    assign em_active = r_desc && (em_bound != crw_pkg::BND_NONE);

    assign o_out_item       = r_out;
    assign o_stat.list_more = r_more;

endmodule

FILE: rtl/constraint_row_allocator.sv
// constraint row allocator: top level joining controller and datapath
//
// one request channel (i_req) carries an action with constraint, bound and row
// fields; one response channel (o_rsp) returns status and the description of
// the constraint or row addressed. a transfer happens when valid and ready are
// both high at a rising edge.
// requests are handled one at a time: i_req.ready is high only while idle.
// after a request transfer the block steps through row lookup (with the
// first-free / next-busy priority encoder), table update and result build and
// then shows the result; the next request is taken only once the final result
// has been taken.
// list answers with one result per busy row in ascending row order, each row
// built anew after the previous result is taken; last marks the final one.
// a stalled receiver holds the result register and the block waits in place.
// synchronous reset clears all tables at once, no sweep; the clear action does
// the same and answers with one result that is all zero but for last.
module constraint_row_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crw_req_if.sink   i_req,
    crw_rsp_if.source o_rsp
);

    crw_pkg::t_ctrl_cmd cmd;
    crw_pkg::t_dp_stat  stat;

    crw_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    crw_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_req.data),
        .o_out_item (o_rsp.data),
        .o_stat     (stat)
    );

endmodule

FILE: rtl/crw_checker.sv
// port-level checks of the constraint row allocator and their bind
module crw_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  crw_pkg::t_out_item i_out_data
);

    // one request in flight at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while previous one still in work");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("result shown while idle");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_data.last) |=> i_in_ready)
        else $error("not idle after final result");

    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.status == crw_pkg::ST_LIST_EMPTY)
            |-> (i_out_data.active_count == 6'd0 && i_out_data.last))
        else $error("empty list with active constraints");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind constraint_row_allocator crw_checker u_crw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
